FILE: hw/rtl/edh_pkg.sv
// Shared types and constants of the elevation distance and height block.
`default_nettype none
package edh_pkg;

    localparam int ITERATIONS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORK_FRAC      = 24;
    localparam int WORK_W         = 64;
    localparam int ANGLE_W        = 17;
    localparam int HEIGHT_W       = 23;
    localparam int OUT_W          = 48;
    localparam int X_W            = ANGLE_W + 8;
    localparam int H24_W          = HEIGHT_W + 8;

    localparam logic [ANGLE_W-1:0]  ANGLE_MAX_RAW = 17'd91750;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = 23'd98304;
    localparam logic [WORK_W-1:0]   MASK48        = 64'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ALPHA = 2'd1,
        ST_BETA  = 2'd2
    } t_status;

    typedef struct packed {
        logic              alpha_ok;
        logic              beta_ok;
        logic              present;
        logic [X_W-1:0]    x_a;
        logic [X_W-1:0]    x_b;
        logic [H24_W-1:0]  h24;
    } t_item;

endpackage
`default_nettype wire

FILE: hw/rtl/edh_if.sv
// Request channel interfaces of the elevation distance and height block.
`default_nettype none
interface edh_in_if;
    logic        valid;
    logic        ready;
    logic [16:0] alpha_angle;
    logic [16:0] beta_angle;
    logic        beta_present;
    modport source(output valid, alpha_angle, beta_angle, beta_present, input ready);
    modport sink(input valid, alpha_angle, beta_angle, beta_present, output ready);
endinterface

interface edh_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] distance_out;
    logic [47:0] object_height;
    logic [1:0]  status;
    logic        saturated;
    modport source(output valid, distance_out, object_height, status, saturated, input ready);
    modport sink(input valid, distance_out, object_height, status, saturated, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/elevation_distance_height.sv
// Top level of the elevation distance and height block.
// Each continued-fraction step is two 64-stage dividers and a subtract stage.
// Throughput: one request per cycle; a stall at the output freezes the whole pipe.
// Reset clears every valid bit and loads the instrument height with 1.5.
`default_nettype none
module elevation_distance_height
    import edh_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [HEIGHT_W-1:0] i_cfg_data,
    edh_in_if.sink                   i_in,
    edh_out_if.source                o_out
);

    localparam int SH  = WORK_FRAC - FRAC_BITS;
    localparam int IW  = $bits(t_item);
    localparam int L   = ITERATIONS;
    localparam logic [WORK_W-1:0] ONE48 = 64'd1 << 48;

    logic en;
    logic [HEIGHT_W-1:0] r_height;

    // The pipe advances whenever the output register is free or being taken.
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_height <= i_cfg_data;
        end
    end

    // Input register.
    logic  r_in_vld;
    t_item r_in_it;
    t_item n_in_it;

    always_comb begin
        n_in_it.alpha_ok = (i_in.alpha_angle != '0) && (i_in.alpha_angle <= ANGLE_MAX_RAW);
        n_in_it.beta_ok  = (i_in.beta_angle != '0) && (i_in.beta_angle <= ANGLE_MAX_RAW);
        n_in_it.present  = i_in.beta_present;
        n_in_it.x_a      = {i_in.alpha_angle, 8'b0};
        n_in_it.x_b      = {i_in.beta_angle, 8'b0};
        n_in_it.h24      = {r_height, 8'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_it <= n_in_it;
        end
    end

    // Continued-fraction chain for both angles side by side.
    logic              s_vld [L+1];
    t_item             s_it  [L+1];
    logic [WORK_W-1:0] s_ra  [L+1];
    logic [WORK_W-1:0] s_rb  [L+1];
    logic              s_ca  [L+1];
    logic              s_cb  [L+1];

    assign s_vld[0] = r_in_vld;
    assign s_it[0]  = r_in_it;
    assign s_ra[0]  = '0;
    assign s_rb[0]  = '0;
    assign s_ca[0]  = 1'b0;
    assign s_cb[0]  = 1'b0;

    for (genvar k = 0; k < L; k++) begin : g_step
        localparam logic [WORK_W-1:0] NUM1 = WORK_W'(2 * (ITERATIONS - k) - 1) << 48;
        localparam int TA1 = IW + WORK_W + 1;
        localparam int TB1 = WORK_W + 1;

        logic              d1a_vld;
        logic [WORK_W-1:0] d1a_quo;
        logic [TA1-1:0]    d1a_tag;
        logic [WORK_W-1:0] d1b_quo;
        logic [TB1-1:0]    d1b_tag;

        edh_div #(.W(WORK_W), .TW(TA1)) u_d1a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_vld[k]),
            .i_num   (NUM1),
            .i_den   ({{(WORK_W-X_W){1'b0}}, s_it[k].x_a}),
            .i_tag   ({s_it[k], s_ra[k], s_ca[k]}),
            .o_valid (d1a_vld),
            .o_quo   (d1a_quo),
            .o_tag   (d1a_tag)
        );

        edh_div #(.W(WORK_W), .TW(TB1)) u_d1b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_vld[k]),
            .i_num   (NUM1),
            .i_den   ({{(WORK_W-X_W){1'b0}}, s_it[k].x_b}),
            .i_tag   ({s_rb[k], s_cb[k]}),
            .o_valid (),
            .o_quo   (d1b_quo),
            .o_tag   (d1b_tag)
        );

        // Denominator stage: q - r, or a clip when it is not positive.
        logic              r_p_vld;
        t_item             r_p_it;
        logic              r_p_ca;
        logic              r_p_cb;
        logic [WORK_W-1:0] r_p_da;
        logic [WORK_W-1:0] r_p_db;
        logic              n_p_ca;
        logic              n_p_cb;
        logic [WORK_W-1:0] ra;
        logic [WORK_W-1:0] rb;

        assign ra     = d1a_tag[WORK_W:1];
        assign rb     = d1b_tag[WORK_W:1];
        assign n_p_ca = d1a_tag[0] || (d1a_quo <= ra);
        assign n_p_cb = d1b_tag[0] || (d1b_quo <= rb);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p_vld <= 1'b0;
            end else if (en) begin
                r_p_vld <= d1a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p_it <= d1a_tag[TA1-1 -: IW];
                r_p_ca <= n_p_ca;
                r_p_cb <= n_p_cb;
                r_p_da <= n_p_ca ? WORK_W'(1) : d1a_quo - ra;
                r_p_db <= n_p_cb ? WORK_W'(1) : d1b_quo - rb;
            end
        end

        logic              d2a_vld;
        logic [WORK_W-1:0] d2a_quo;
        logic [IW:0]       d2a_tag;
        logic [WORK_W-1:0] d2b_quo;
        logic              d2b_tag;

        edh_div #(.W(WORK_W), .TW(IW + 1)) u_d2a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_p_vld),
            .i_num   (ONE48),
            .i_den   (r_p_da),
            .i_tag   ({r_p_it, r_p_ca}),
            .o_valid (d2a_vld),
            .o_quo   (d2a_quo),
            .o_tag   (d2a_tag)
        );

        edh_div #(.W(WORK_W), .TW(1)) u_d2b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_p_vld),
            .i_num   (ONE48),
            .i_den   (r_p_db),
            .i_tag   (r_p_cb),
            .o_valid (),
            .o_quo   (d2b_quo),
            .o_tag   (d2b_tag)
        );

        assign s_vld[k+1] = d2a_vld;
        assign s_it[k+1]  = d2a_tag[IW:1];
        assign s_ca[k+1]  = d2a_tag[0];
        assign s_cb[k+1]  = d2b_tag;
        assign s_ra[k+1]  = d2a_tag[0] ? MASK48 : d2a_quo;
        assign s_rb[k+1]  = d2b_tag ? MASK48 : d2b_quo;
    end

    // Distance division h24 << 24 / tan(alpha).
    logic              r_q_vld;
    t_item             r_q_it;
    logic              r_q_tz;
    logic              r_q_ca;
    logic              r_q_cb;
    logic [WORK_W-1:0] r_q_den;
    logic [WORK_W-1:0] r_q_tb;
    logic              n_q_tz;

    assign n_q_tz = s_ra[L] == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (en) begin
            r_q_vld <= s_vld[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_it  <= s_it[L];
            r_q_tz  <= n_q_tz;
            r_q_ca  <= s_ca[L] || n_q_tz;
            r_q_cb  <= s_cb[L];
            r_q_den <= n_q_tz ? WORK_W'(1) : s_ra[L];
            r_q_tb  <= s_rb[L];
        end
    end

    localparam int T3 = IW + WORK_W + 3;

    logic              d3_vld;
    logic [WORK_W-1:0] d3_quo;
    logic [T3-1:0]     d3_tag;

    edh_div #(.W(WORK_W), .TW(T3)) u_d3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_q_vld),
        .i_num   ({{(WORK_W-H24_W-24){1'b0}}, r_q_it.h24, 24'b0}),
        .i_den   (r_q_den),
        .i_tag   ({r_q_it, r_q_ca, r_q_cb, r_q_tz, r_q_tb}),
        .o_valid (d3_vld),
        .o_quo   (d3_quo),
        .o_tag   (d3_tag)
    );

    t_item             d3_it;
    logic              d3_ca;
    logic              d3_cb;
    logic              d3_tz;
    logic [WORK_W-1:0] d3_tb;
    logic [WORK_W-1:0] d24;
    logic [WORK_W-1:0] d_sh;

    assign d3_it = d3_tag[T3-1 -: IW];
    assign d3_ca = d3_tag[WORK_W+2];
    assign d3_cb = d3_tag[WORK_W+1];
    assign d3_tz = d3_tag[WORK_W];
    assign d3_tb = d3_tag[WORK_W-1:0];
    assign d24   = d3_tz ? MASK48 : d3_quo;
    assign d_sh  = d24 >> SH;

    // Partial products of d24 * tan(beta); tan(beta) never exceeds 2^48.
    logic              r_m_vld;
    t_item             r_m_it;
    logic              r_m_ca;
    logic              r_m_cb;
    logic              r_m_dsat;
    logic [OUT_W-1:0]  r_m_dist;
    logic [56:0]       r_m_phh;
    logic [55:0]       r_m_phl;
    logic [48:0]       r_m_plh;
    logic [47:0]       r_m_pll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= d3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_it   <= d3_it;
            r_m_ca   <= d3_ca;
            r_m_cb   <= d3_cb;
            r_m_dsat <= |d_sh[WORK_W-1:OUT_W];
            r_m_dist <= d_sh[OUT_W-1:0];
            r_m_phh  <= d24[55:24] * d3_tb[48:24];
            r_m_phl  <= d24[55:24] * d3_tb[23:0];
            r_m_plh  <= d24[23:0] * d3_tb[48:24];
            r_m_pll  <= d24[23:0] * d3_tb[23:0];
        end
    end

    // Sum stage; wraps at 64 bits.
    logic              r_s_vld;
    t_item             r_s_it;
    logic              r_s_ca;
    logic              r_s_cb;
    logic              r_s_dsat;
    logic [OUT_W-1:0]  r_s_dist;
    logic [WORK_W-1:0] r_s_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_s_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_it   <= r_m_it;
            r_s_ca   <= r_m_ca;
            r_s_cb   <= r_m_cb;
            r_s_dsat <= r_m_dsat;
            r_s_dist <= r_m_dist;
            r_s_v    <= WORK_W'({r_m_phh, 24'b0}) + WORK_W'(r_m_phl) + WORK_W'(r_m_plh)
                      + WORK_W'(r_m_pll[47:24]) + WORK_W'(r_m_it.h24);
        end
    end

    // Output register.
    logic              r_o_vld;
    logic [OUT_W-1:0]  r_o_dist;
    logic [OUT_W-1:0]  r_o_obj;
    t_status           r_o_status;
    logic              r_o_sat;
    logic [WORK_W-1:0] v_sh;
    logic              osat;
    logic              beta_used;
    logic [OUT_W-1:0]  n_o_dist;
    logic [OUT_W-1:0]  n_o_obj;
    t_status           n_o_status;
    logic              n_o_sat;

    assign v_sh      = r_s_v >> SH;
    assign osat      = |v_sh[WORK_W-1:OUT_W];
    assign beta_used = r_s_it.present && r_s_it.beta_ok;

    always_comb begin
        n_o_dist   = '0;
        n_o_obj    = '0;
        n_o_status = ST_OK;
        n_o_sat    = 1'b0;
        if (!r_s_it.alpha_ok) begin
            n_o_status = ST_ALPHA;
        end else begin
            n_o_dist = r_s_dsat ? MASK48[OUT_W-1:0] : r_s_dist;
            n_o_sat  = r_s_ca || r_s_dsat || (beta_used && (r_s_cb || osat));
            if (r_s_it.present && !r_s_it.beta_ok) begin
                n_o_status = ST_BETA;
            end
            if (beta_used) begin
                n_o_obj = osat ? MASK48[OUT_W-1:0] : v_sh[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_dist   <= n_o_dist;
            r_o_obj    <= n_o_obj;
            r_o_status <= n_o_status;
            r_o_sat    <= n_o_sat;
        end
    end

    assign o_out.valid         = r_o_vld;
    assign o_out.distance_out  = r_o_dist;
    assign o_out.object_height = r_o_obj;
    assign o_out.status        = r_o_status;
    assign o_out.saturated     = r_o_sat;

endmodule
`default_nettype wire

FILE: hw/rtl/edh_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag riding along.
`default_nettype none
module edh_div #(
    parameter int W  = 64,
    parameter int TW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [W-1:0]       o_quo,
    output logic [TW-1:0]      o_tag
);

    logic          r_vld [W];
    logic [W-1:0]  r_rem [W];
    logic [W-1:0]  r_nq  [W];
    logic [W-1:0]  r_den [W];
    logic [TW-1:0] r_tag [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic          p_vld;
        logic [W-1:0]  p_rem;
        logic [W-1:0]  p_nq;
        logic [W-1:0]  p_den;
        logic [TW-1:0] p_tag;
        logic [W:0]    sh;
        logic          ge;
        logic [W:0]    diff;

        if (i == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_rem = '0;
            assign p_nq  = i_num;
            assign p_den = i_den;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_vld = r_vld[i-1];
            assign p_rem = r_rem[i-1];
            assign p_nq  = r_nq[i-1];
            assign p_den = r_den[i-1];
            assign p_tag = r_tag[i-1];
        end

        // Bring down the next dividend bit and subtract when it fits.
        assign sh   = {p_rem, p_nq[W-1]};
        assign ge   = sh >= {1'b0, p_den};
        assign diff = sh - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= ge ? diff[W-1:0] : sh[W-1:0];
                r_nq[i]  <= {p_nq[W-2:0], ge};
                r_den[i] <= p_den;
                r_tag[i] <= p_tag;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_nq[W-1];
    assign o_tag   = r_tag[W-1];

endmodule
`default_nettype wire
